FILE: rtl/core/rgblab_pkg.sv
// Package for the RGB to CIE L*a*b* pixel unit: widths, matrix coefficients
// and the reciprocal constants used for division by fixed divisors.
// No dependencies.
package rgblab_pkg;

    localparam int CH_W   = 8;    // channel byte
    localparam int T_W    = 17;   // X, Y, Z in unsigned Q1.16
    localparam int F_W    = 17;   // f(t) in unsigned Q1.16
    localparam int S_W    = 34;   // matrix row sum, Q0.24 times a byte
    localparam int Q1_W   = 26;   // row sum after the divide by 256
    localparam int P_W    = 53;   // reciprocal product for the divide by 255
    localparam int L_W    = 15;
    localparam int AB_W   = 16;
    localparam int V_W    = 30;   // signed Q.16 intermediate outputs

    localparam int OUT_FRAC_BITS_DEF = 8;

    typedef logic [23:0]              t_coef;
    typedef logic [T_W-1:0]           t_xyz;
    typedef logic [F_W-1:0]           t_fval;
    typedef logic signed [V_W-1:0]    t_v;

    // Coefficients held as round(k * 2^24), k given to seven decimals.
    localparam longint unsigned QS = 64'd16777216;
    localparam longint unsigned QH = 64'd5000000;
    localparam longint unsigned QD = 64'd10000000;

    localparam t_coef MAT [9] = '{
        t_coef'((64'd4306190 * QS + QH) / QD),
        t_coef'((64'd3415419 * QS + QH) / QD),
        t_coef'((64'd1783091 * QS + QH) / QD),
        t_coef'((64'd2220379 * QS + QH) / QD),
        t_coef'((64'd7066384 * QS + QH) / QD),
        t_coef'((64'd713236  * QS + QH) / QD),
        t_coef'((64'd201853  * QS + QH) / QD),
        t_coef'((64'd1295504 * QS + QH) / QD),
        t_coef'((64'd9390944 * QS + QH) / QD)
    };

    // floor(x / 255) = (x * DIV255_M) >> DIV255_SH for x below 2^26
    localparam logic [26:0] DIV255_M  = 27'd67372037;
    localparam int          DIV255_SH = 34;
    localparam logic [S_W-1:0] ROW_RND = S_W'(32640);

    // Linear branch: (24389*t + 432*65536 + 1566) / 3132, divide by 4 then
    // by 783 through a reciprocal that is exact below 2^24.
    localparam int           LIN_T_MAX = 580;   // cube root above this
    localparam logic [14:0]  LIN_MUL   = 15'd24389;
    localparam logic [30:0]  LIN_ADD   = 31'd28313118;
    localparam logic [24:0]  DIV783_M  = 25'd21941085;
    localparam int           DIV783_SH = 34;

    localparam int CBRT_BITS = 18;   // root digits, one stage each
    localparam int Y3_W      = 57;

    // Pipeline depth: matrix (2), cube root (CBRT_BITS + 1), output (2)
    localparam int LAT = 2 + CBRT_BITS + 1 + 2;

endpackage

FILE: rtl/core/rgblab_if.sv
// Channel interfaces of the RGB to CIE L*a*b* pixel unit: pixel in, Lab out.
// Depends on rgblab_pkg for field widths.
interface rgblab_pix_if import rgblab_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgblab_res_if import rgblab_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [L_W-1:0]         l_star;
    logic signed [AB_W-1:0] a_star;
    logic signed [AB_W-1:0] b_star;

    modport source (output valid, l_star, a_star, b_star, input ready);
    modport sink   (input valid, l_star, a_star, b_star, output ready);
endinterface

FILE: rtl/core/rgb_to_cielab_pixel_unit.sv
// Top level of the RGB to CIE L*a*b* pixel unit.
// Depends on rgblab_pkg, rgblab_if, rgblab_mat, rgblab_labf, rgblab_out.
//
//   port    dir  modport  payload                    transfer when
//   i_pix   in   sink     red, green, blue (8 b)     valid && ready
//   o_lab   out  source   l_star, a_star, b_star     valid && ready
//
// One pixel per cycle while the output is not held; every pixel gives one result
// through LAT register stages (matrix 2, cube root 18 digit stages plus rounding, output 2).
// The pipeline advances as a whole; it holds only while a result sits in
// the output register and the sink refuses it, so i_pix.ready follows
// !o_lab.valid || o_lab.ready. Bubbles travel as cleared valid bits.
// Reset clears the valid bits only; data registers carry no reset.
module rgb_to_cielab_pixel_unit import rgblab_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgblab_pix_if.sink  i_pix,
    rgblab_res_if.source o_lab
);

    logic           en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    t_xyz           t_xyz_v [3];
    t_fval          f_v [3];

    // Advance everything unless the finished result is held by the sink
    assign en          = !r_vld[LAT-1] || o_lab.ready;
    assign i_pix.ready = en;
    assign o_lab.valid = r_vld[LAT-1];

    always_comb begin
        n_vld = {r_vld[LAT-2:0], i_pix.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    rgblab_mat u_mat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_t     (t_xyz_v)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_f
            rgblab_labf u_labf (
                .i_clk (i_clk),
                .i_en  (en),
                .i_t   (t_xyz_v[c]),
                .o_f   (f_v[c])
            );
        end
    endgenerate

    rgblab_out #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_out (
        .i_clk (i_clk),
        .i_en  (en),
        .i_fx  (f_v[0]),
        .i_fy  (f_v[1]),
        .i_fz  (f_v[2]),
        .o_l   (o_lab.l_star),
        .o_a   (o_lab.a_star),
        .o_b   (o_lab.b_star)
    );

    // A held result blocks new transfers in
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lab.valid && !o_lab.ready |-> !i_pix.ready)
        else $error("input taken while output stalled");

    // A stall freezes the valid bits
    a_stall_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // The item one stage before the output arrives on the next advance
    a_arrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[LAT-2] |=> o_lab.valid)
        else $error("result lost before output");

    // Lightness never leaves its range
    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lab.valid |-> o_lab.l_star <= L_W'(100 << OUT_FRAC_BITS))
        else $error("l_star above 100");

endmodule

FILE: rtl/core/rgblab_mat.sv
// Colour matrix stage: three row sums, then the rounded divide by 255*256.
// Two register stages. Depends on rgblab_pkg.
module rgblab_mat import rgblab_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output t_xyz            o_t [3]
);

    logic [S_W-1:0] r_s [3];
    logic [S_W-1:0] n_s [3];
    logic [P_W-1:0] r_p [3];
    logic [P_W-1:0] n_p [3];
    logic [S_W-1:0] rnd [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s[r] = S_W'(MAT[3*r])     * S_W'(i_red)
                   + S_W'(MAT[3*r + 1]) * S_W'(i_green)
                   + S_W'(MAT[3*r + 2]) * S_W'(i_blue);
            rnd[r] = (r_s[r] + ROW_RND) >> 8;
            n_p[r] = P_W'(rnd[r][Q1_W-1:0]) * P_W'(DIV255_M);
            o_t[r] = r_p[r][DIV255_SH +: T_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
            r_p <= n_p;
        end
    end

endmodule

FILE: rtl/core/rgblab_labf.sv
// f(t) of one channel: restoring cube root, one digit per stage, with the
// linear branch computed alongside. CBRT_BITS + 1 stages. Depends on rgblab_pkg.
module rgblab_labf import rgblab_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_xyz  i_t,
    output t_fval o_f
);

    logic [T_W-1:0]  r_t  [CBRT_BITS];
    logic [17:0]     r_y  [CBRT_BITS];
    logic [35:0]     r_y2 [CBRT_BITS];
    logic [Y3_W-1:0] r_y3 [CBRT_BITS];

    logic [30:0]     r_lx;
    logic [53:0]     r_lp;
    t_fval           r_lf [2:CBRT_BITS-1];
    t_fval           r_f;

    genvar s;
    generate
        for (s = 0; s < CBRT_BITS; s++) begin : g_dig
            localparam int B = CBRT_BITS - 1 - s;
            logic [T_W-1:0]  t_in;
            logic [17:0]     y_in;
            logic [35:0]     y2_in;
            logic [Y3_W-1:0] y3_in;
            logic [17:0]     c;
            logic [35:0]     c2;
            logic [Y3_W-1:0] c3;
            logic [Y3_W-1:0] n_val;
            logic            take;

            if (s == 0) begin : g_first
                assign t_in  = i_t;
                assign y_in  = '0;
                assign y2_in = '0;
                assign y3_in = '0;
            end else begin : g_next
                assign t_in  = r_t[s-1];
                assign y_in  = r_y[s-1];
                assign y2_in = r_y2[s-1];
                assign y3_in = r_y3[s-1];
            end

            // (y + 2^B)^2 and (y + 2^B)^3 from the running square and cube
            always_comb begin
                n_val = Y3_W'(t_in) << 32;
                c     = y_in | (18'd1 << B);
                c2    = y2_in + (36'(y_in) << (B + 1)) + (36'd1 << (2 * B));
                c3    = y3_in
                      + ((Y3_W'(y2_in) + (Y3_W'(y2_in) << 1)) << B)
                      + ((Y3_W'(y_in) + (Y3_W'(y_in) << 1)) << (2 * B))
                      + (Y3_W'(1) << (3 * B));
                take  = (c3 <= n_val);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[s]  <= t_in;
                    r_y[s]  <= take ? c  : y_in;
                    r_y2[s] <= take ? c2 : y2_in;
                    r_y3[s] <= take ? c3 : y3_in;
                end
            end
        end

        for (s = 3; s < CBRT_BITS; s++) begin : g_lin
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lf[s] <= r_lf[s-1];
                end
            end
        end
    endgenerate

    // Round to nearest: add one when (2y+1)^3 < 8N
    logic [Y3_W-1:0] tw;
    logic [Y3_W-1:0] n8;
    logic            inc;
    logic            cube;
    logic [17:0]     yl;
    logic [35:0]     y2l;

    always_comb begin
        yl   = r_y[CBRT_BITS-1];
        y2l  = r_y2[CBRT_BITS-1];
        tw   = (r_y3[CBRT_BITS-1] << 3) + (Y3_W'(y2l) << 3) + (Y3_W'(y2l) << 2)
             + (Y3_W'(yl) << 2) + (Y3_W'(yl) << 1) + Y3_W'(1);
        n8   = Y3_W'(r_t[CBRT_BITS-1]) << 35;
        inc  = (tw < n8);
        cube = (r_t[CBRT_BITS-1] > T_W'(LIN_T_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lx    <= 31'(LIN_MUL) * 31'(i_t) + LIN_ADD;
            r_lp    <= 54'(r_lx[30:2]) * 54'(DIV783_M);
            r_lf[2] <= r_lp[DIV783_SH +: F_W];
            r_f     <= cube ? (F_W'(yl) + F_W'(inc)) : r_lf[CBRT_BITS-1];
        end
    end

    assign o_f = r_f;

endmodule

FILE: rtl/core/rgblab_out.sv
// Output stage: L*, a*, b* in Q.16, then round half up to OUT_FRAC_BITS and
// saturate. Two register stages. Depends on rgblab_pkg.
module rgblab_out import rgblab_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_fval                  i_fx,
    input  t_fval                  i_fy,
    input  t_fval                  i_fz,
    output logic [L_W-1:0]         o_l,
    output logic signed [AB_W-1:0] o_a,
    output logic signed [AB_W-1:0] o_b
);

    localparam int SH   = 16 - OUT_FRAC_BITS;
    localparam t_v RND  = t_v'(1) <<< (SH - 1);
    localparam t_v LMAX = t_v'(100) <<< OUT_FRAC_BITS;
    localparam t_v AMIN = -t_v'(32768);
    localparam t_v AMAX = t_v'(32767);

    t_v r_vl, r_va, r_vb;
    t_v n_vl, n_va, n_vb;
    t_v wl, wa, wb;
    logic [L_W-1:0]         r_l, n_l;
    logic signed [AB_W-1:0] r_a, r_b, n_a, n_b;

    always_comb begin
        n_vl = t_v'(i_fy) * t_v'(116) - t_v'(1048576);
        n_va = (t_v'(i_fx) - t_v'(i_fy)) * t_v'(500);
        n_vb = (t_v'(i_fy) - t_v'(i_fz)) * t_v'(200);

        wl = (r_vl + RND) >>> SH;
        wa = (r_va + RND) >>> SH;
        wb = (r_vb + RND) >>> SH;

        if (wl < 0)         n_l = '0;
        else if (wl > LMAX) n_l = L_W'(LMAX);
        else                n_l = L_W'(wl);

        if (wa < AMIN)      n_a = AB_W'(AMIN);
        else if (wa > AMAX) n_a = AB_W'(AMAX);
        else                n_a = AB_W'(wa);

        if (wb < AMIN)      n_b = AB_W'(AMIN);
        else if (wb > AMAX) n_b = AB_W'(AMAX);
        else                n_b = AB_W'(wb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vl <= n_vl;
            r_va <= n_va;
            r_vb <= n_vb;
            r_l  <= n_l;
            r_a  <= n_a;
            r_b  <= n_b;
        end
    end

    assign o_l = r_l;
    assign o_a = r_a;
    assign o_b = r_b;

endmodule

FILE: dv/rgb_to_cielab_pixel_unit_test.sv
// Testbench for the RGB to CIE L*a*b* pixel unit: directed and random pixels
// with random gaps on both channels, results checked against a bit-true predictor.
// Depends on rgblab_pkg, rgblab_if and the unit's RTL.
module rgb_to_cielab_pixel_unit_test import rgblab_pkg::*; ();

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [L_W-1:0]         l_star;
        logic signed [AB_W-1:0] a_star;
        logic signed [AB_W-1:0] b_star;
    } t_lab;

    localparam int OFB = OUT_FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    rgblab_pix_if pix_bus ();
    rgblab_res_if lab_bus ();

    rgb_to_cielab_pixel_unit #(.OUT_FRAC_BITS(OFB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_bus.sink),
        .o_lab  (lab_bus.source)
    );

    t_pixel pixel_queue [$];
    t_lab   lab_expected [$];
    int     mismatches = 0;
    longint cycle_count = 0;
    bit     hold_sender;
    int     send_gap;
    int     take_gap;

    // Matrix coefficients as round(k * 2^24)
    function automatic longint coef_q24(longint k);
        return (k * 64'd16777216 + 64'd5000000) / 64'd10000000;
    endfunction

    // f(t) in Q1.16: cube root above 216/24389, linear segment below
    function automatic longint lab_curve(longint t);
        longint n, y, c, tw;
        if (t * 24389 > 216 * 65536) begin
            n = t <<< 32;
            y = 0;
            for (int bitpos = 17; bitpos >= 0; bitpos--) begin
                c = y | (longint'(1) <<< bitpos);
                if (c * c * c <= n) y = c;
            end
            tw = 2 * y + 1;
            if (tw * tw * tw < 8 * n) y++;
            return y;
        end
        return (24389 * t + 432 * 65536 + 1566) / 3132;
    endfunction

    // Drop to OFB fraction bits, rounding half up (floor toward minus infinity)
    function automatic longint round_q16(longint v);
        longint w;
        w = v + (longint'(1) <<< (15 - OFB));
        return w >>> (16 - OFB);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_lab convert_pixel(t_pixel p);
        longint k [9];
        longint ch [3];
        longint fv [3];
        longint s, t, l, a, b;
        t_lab r;
        k = '{coef_q24(4306190), coef_q24(3415419), coef_q24(1783091),
              coef_q24(2220379), coef_q24(7066384), coef_q24(713236),
              coef_q24(201853),  coef_q24(1295504), coef_q24(9390944)};
        ch = '{longint'(p.red), longint'(p.green), longint'(p.blue)};
        for (int i = 0; i < 3; i++) begin
            s = k[3*i] * ch[0] + k[3*i+1] * ch[1] + k[3*i+2] * ch[2];
            t = (s + 32640) / 65280;
            fv[i] = lab_curve(t);
        end
        l = clamp(round_q16(116 * fv[1] - 16 * 65536), 0, 100 <<< OFB);
        a = clamp(round_q16(500 * (fv[0] - fv[1])), -32768, 32767);
        b = clamp(round_q16(200 * (fv[1] - fv[2])), -32768, 32767);
        r.l_star = l[L_W-1:0];
        r.a_star = a[AB_W-1:0];
        r.b_star = b[AB_W-1:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: one pixel at a time with a drawn gap before each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
            pix_bus.red   <= '0;
            pix_bus.green <= '0;
            pix_bus.blue  <= '0;
            send_gap = 0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                lab_expected.push_back(convert_pixel({pix_bus.red, pix_bus.green,
                                                      pix_bus.blue}));
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
            if ((!pix_bus.valid || pix_bus.ready)) begin
                if (send_gap > 0 || hold_sender || pixel_queue.size() == 0) begin
                    pix_bus.valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    t_pixel p;
                    p = pixel_queue.pop_front();
                    pix_bus.valid <= 1'b1;
                    pix_bus.red   <= p.red;
                    pix_bus.green <= p.green;
                    pix_bus.blue  <= p.blue;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction,
    // and draw a stall before accepting the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lab_bus.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (lab_bus.valid && lab_bus.ready) begin
                if (lab_expected.size() == 0) begin
                    $display("%0t: result with no pixel pending: actual %h %h %h", $time,
                             lab_bus.l_star, lab_bus.a_star, lab_bus.b_star);
                    mismatches++;
                end else begin
                    t_lab e;
                    e = lab_expected.pop_front();
                    if (lab_bus.l_star !== e.l_star) begin
                        $display("%0t: l_star expected %0d actual %0d", $time,
                                 e.l_star, lab_bus.l_star);
                        mismatches++;
                    end
                    if (lab_bus.a_star !== e.a_star) begin
                        $display("%0t: a_star expected %0d actual %0d", $time,
                                 e.a_star, lab_bus.a_star);
                        mismatches++;
                    end
                    if (lab_bus.b_star !== e.b_star) begin
                        $display("%0t: b_star expected %0d actual %0d", $time,
                                 e.b_star, lab_bus.b_star);
                        mismatches++;
                    end
                end
                take_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
            if (take_gap > 0) begin
                take_gap--;
                lab_bus.ready <= 1'b0;
            end else begin
                lab_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the cycle count
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel p;
        case ($urandom_range(0, 4))
            0:       p = {8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                          8'($urandom_range(0, 8))};   // near the linear segment
            1:       p = {8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
                          8'($urandom_range(240, 255))};
            default: p = t_pixel'(24'($urandom));
        endcase
        return p;
    endfunction

    // Stimulus
    initial begin
        hold_sender = 1'b0;
        // black, white, primaries, secondaries, threshold region, single bits
        pixel_queue.push_back({8'd0,   8'd0,   8'd0});
        pixel_queue.push_back({8'd255, 8'd255, 8'd255});
        pixel_queue.push_back({8'd255, 8'd0,   8'd0});
        pixel_queue.push_back({8'd0,   8'd255, 8'd0});
        pixel_queue.push_back({8'd0,   8'd0,   8'd255});
        pixel_queue.push_back({8'd255, 8'd255, 8'd0});
        pixel_queue.push_back({8'd0,   8'd255, 8'd255});
        pixel_queue.push_back({8'd255, 8'd0,   8'd255});
        pixel_queue.push_back({8'd1,   8'd1,   8'd1});
        pixel_queue.push_back({8'd2,   8'd2,   8'd2});
        pixel_queue.push_back({8'd3,   8'd3,   8'd3});
        pixel_queue.push_back({8'd0,   8'd3,   8'd0});
        pixel_queue.push_back({8'd0,   8'd0,   8'd1});
        pixel_queue.push_back({8'd128, 8'd128, 8'd128});
        pixel_queue.push_back({8'd170, 8'd85,  8'd170});
        pixel_queue.push_back({8'd85,  8'd170, 8'd85});
        pixel_queue.push_back({8'd254, 8'd1,   8'd127});
        wait (i_rst_n);
        for (int n = 0; n < 270; n++) pixel_queue.push_back(random_pixel());
        wait (pixel_queue.size() == 0);
        // hold the sender until the pipeline has drained
        hold_sender = 1'b1;
        wait (lab_expected.size() == 0 && !pix_bus.valid);
        hold_sender = 1'b0;
        for (int n = 0; n < 270; n++) pixel_queue.push_back(random_pixel());
        wait (pixel_queue.size() == 0 && !pix_bus.valid);
        wait (lab_expected.size() == 0);
        repeat (LAT + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
